// ===== rtl/core/enc_mt_pkg.sv =====
// shared types, constants and helpers of the multiturn encoder frame tracker
// no dependencies; used by every file of the block
package enc_mt_pkg;

	localparam int CHANNELS_DEF = 2;
	localparam int CH_MAX_W     = 3;
	localparam int BYTE_W       = 8;
	localparam int ANGLE_W      = 10;
	localparam int COUNT_W      = 16;
	localparam int DATA_W       = 15;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 10;
	localparam int QUEUE_DEPTH  = 2;
	localparam int QPTR_W       = 1;
	localparam int QCNT_W       = 2;

	localparam logic [ANGLE_W-1:0] WRAP_HIGH_RST = 10'd800;
	localparam logic [ANGLE_W-1:0] WRAP_LOW_RST  = 10'd300;
	localparam logic [ANGLE_W-1:0] ANGLE_CH0_RST = 10'd512;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_WRAP_HIGH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_WRAP_LOW  = 1'b1;

	typedef struct packed {
		logic [CH_MAX_W-1:0] ch;
		logic                ok;
		logic [ANGLE_W-1:0]  angle;
	} frame_t;

	typedef struct packed {
		logic                  we;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
	} cfg_wr_t;

	function automatic int ch_width(input int n);
		ch_width = (n > 1) ? $clog2(n) : 1;
	endfunction

endpackage

// ===== rtl/core/enc_mt_ifs.sv =====
// valid/ready channel interfaces of the multiturn encoder frame tracker
// depends on enc_mt_pkg
interface enc_mt_byte_if;
	logic                          valid;
	logic                          ready;
	logic [enc_mt_pkg::BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface enc_mt_result_if;
	logic                           valid;
	logic                           ready;
	logic                           channel;
	logic                           frame_valid;
	logic [enc_mt_pkg::ANGLE_W-1:0] angle;
	logic [enc_mt_pkg::COUNT_W-1:0] turns;
	logic [enc_mt_pkg::COUNT_W-1:0] position;
	logic [enc_mt_pkg::COUNT_W-1:0] miss_count;

	modport source (output valid, output channel, output frame_valid, output angle,
		output turns, output position, output miss_count, input ready);
	modport sink (input valid, input channel, input frame_valid, input angle,
		input turns, input position, input miss_count, output ready);
endinterface

// ===== rtl/core/enc_mt_front.sv =====
// front end: assembles three-byte frames, checks parity and status, picks the channel
// depends on enc_mt_pkg and enc_mt_byte_if
module enc_mt_front #(
	parameter int CHANNELS = enc_mt_pkg::CHANNELS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	enc_mt_byte_if.sink         rx,
	output logic                push,
	output enc_mt_pkg::frame_t  frame,
	input  logic                q_ready
);

	localparam int CH_W = enc_mt_pkg::ch_width(CHANNELS);
	localparam logic [CH_W-1:0] CH_LAST = CH_W'(CHANNELS - 1);

	localparam logic [1:0] BIDX_FIRST  = 2'd0;
	localparam logic [1:0] BIDX_SECOND = 2'd1;
	localparam logic [1:0] BIDX_THIRD  = 2'd2;

	logic [1:0]                          byte_idx_q;
	logic [enc_mt_pkg::BYTE_W-1:0]       first_q;
	logic [enc_mt_pkg::BYTE_W-1:0]       second_q;
	logic [CH_W-1:0]                     ch_q;
	logic                                last_byte;
	logic                                accept;
	logic [enc_mt_pkg::DATA_W-1:0]       data;
	logic                                ok;

	// index three cannot occur but closes a frame like index two
	assign last_byte = byte_idx_q[1];
	assign rx.ready  = !last_byte || q_ready;
	assign accept    = rx.valid && rx.ready;

	assign data = {first_q[6:0], second_q};
	assign ok   = ((^data) == rx.rx_byte[7]) && second_q[4] && !second_q[3];

	assign push        = accept && last_byte;
	assign frame.ch    = enc_mt_pkg::CH_MAX_W'(ch_q);
	assign frame.ok    = ok;
	assign frame.angle = data[14:5];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_idx_q <= BIDX_FIRST;
			first_q    <= '0;
			second_q   <= '0;
			ch_q       <= '0;
		end else if (accept) begin
			if (last_byte) begin
				byte_idx_q <= BIDX_FIRST;
				ch_q       <= (ch_q == CH_LAST) ? '0 : ch_q + 1'b1;
			end else if (byte_idx_q == BIDX_FIRST) begin
				first_q    <= rx.rx_byte;
				byte_idx_q <= BIDX_SECOND;
			end else begin
				second_q   <= rx.rx_byte;
				byte_idx_q <= BIDX_THIRD;
			end
		end
	end

endmodule

// ===== rtl/core/enc_mt_queue.sv =====
// two-entry frame queue between the front end and the tracker
// depends on enc_mt_pkg
module enc_mt_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  enc_mt_pkg::frame_t  wr_frame,
	output logic                wr_ready,
	input  logic                pop,
	output enc_mt_pkg::frame_t  rd_frame,
	output logic                rd_valid
);

	enc_mt_pkg::frame_t                mem_q [enc_mt_pkg::QUEUE_DEPTH];
	logic [enc_mt_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [enc_mt_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [enc_mt_pkg::QCNT_W-1:0]     count_q;
	logic                              do_push;
	logic                              do_pop;

	assign wr_ready = count_q != enc_mt_pkg::QCNT_W'(enc_mt_pkg::QUEUE_DEPTH);
	assign rd_valid = count_q != '0;
	assign rd_frame = mem_q[rd_ptr_q];
	assign do_push  = push && wr_ready;
	assign do_pop   = pop && rd_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_frame;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/enc_mt_back.sv =====
// tracker: per-channel angle, turn and miss state, wrap thresholds, result register
// depends on enc_mt_pkg and enc_mt_result_if
module enc_mt_back #(
	parameter int CHANNELS = enc_mt_pkg::CHANNELS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  enc_mt_pkg::cfg_wr_t cfg,
	input  logic                q_valid,
	input  enc_mt_pkg::frame_t  q_frame,
	output logic                pop,
	enc_mt_result_if.source     res
);

	localparam int CH_W = enc_mt_pkg::ch_width(CHANNELS);

	logic [enc_mt_pkg::ANGLE_W-1:0] wrap_high_q;
	logic [enc_mt_pkg::ANGLE_W-1:0] wrap_low_q;
	logic [enc_mt_pkg::ANGLE_W-1:0] angle_q [CHANNELS];
	logic [enc_mt_pkg::COUNT_W-1:0] turns_q [CHANNELS];
	logic [enc_mt_pkg::COUNT_W-1:0] miss_q  [CHANNELS];
	logic [enc_mt_pkg::COUNT_W-1:0] pos_q   [CHANNELS];
	logic                           res_valid_q;

	logic [CH_W-1:0]                c;
	logic [enc_mt_pkg::ANGLE_W-1:0] prev;
	logic                           fwd;
	logic                           bwd;
	logic [enc_mt_pkg::COUNT_W-1:0] turns_next;
	logic [enc_mt_pkg::COUNT_W-1:0] pos_next;
	logic [enc_mt_pkg::COUNT_W-1:0] miss_next;
	logic [enc_mt_pkg::ANGLE_W-1:0] angle_out;
	logic [enc_mt_pkg::COUNT_W-1:0] turns_out;
	logic [enc_mt_pkg::COUNT_W-1:0] pos_out;

	assign pop       = q_valid && (!res_valid_q || res.ready);
	assign res.valid = res_valid_q;

	assign c    = q_frame.ch[CH_W-1:0];
	assign prev = angle_q[c];
	// forward wins when both wrap conditions hold
	assign fwd  = (prev > wrap_high_q) && (q_frame.angle < wrap_low_q);
	assign bwd  = (prev < wrap_low_q) && (q_frame.angle > wrap_high_q);

	always_comb begin
		turns_next = turns_q[c];
		if (fwd) begin
			turns_next = turns_q[c] + 1'b1;
		end else if (bwd) begin
			turns_next = turns_q[c] - 1'b1;
		end
	end

	assign pos_next  = {turns_next[enc_mt_pkg::COUNT_W-enc_mt_pkg::ANGLE_W-1:0], q_frame.angle};
	assign miss_next = q_frame.ok ? '0 : ((miss_q[c] == '1) ? miss_q[c] : miss_q[c] + 1'b1);
	assign angle_out = q_frame.ok ? q_frame.angle : angle_q[c];
	assign turns_out = q_frame.ok ? turns_next : turns_q[c];
	assign pos_out   = q_frame.ok ? pos_next : pos_q[c];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_high_q <= enc_mt_pkg::WRAP_HIGH_RST;
			wrap_low_q  <= enc_mt_pkg::WRAP_LOW_RST;
			res_valid_q <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				angle_q[i] <= (i == 0) ? enc_mt_pkg::ANGLE_CH0_RST : '0;
				turns_q[i] <= '0;
				miss_q[i]  <= '0;
				pos_q[i]   <= '0;
			end
		end else begin
			if (cfg.we) begin
				case (cfg.idx)
					enc_mt_pkg::CFG_WRAP_HIGH: wrap_high_q <= cfg.data;
					enc_mt_pkg::CFG_WRAP_LOW:  wrap_low_q  <= cfg.data;
					default: ;
				endcase
			end
			if (pop) begin
				res_valid_q <= 1'b1;
				angle_q[c]  <= angle_out;
				turns_q[c]  <= turns_out;
				miss_q[c]   <= miss_next;
				pos_q[c]    <= pos_out;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res.channel     <= q_frame.ch[0];
			res.frame_valid <= q_frame.ok;
			res.angle       <= angle_out;
			res.turns       <= turns_out;
			res.position    <= pos_out;
			res.miss_count  <= miss_next;
		end
	end

endmodule

// ===== rtl/core/encoder_frame_multiturn_tracker_top.sv =====
// Multiturn absolute encoder frame tracker.
// Input channel rx carries one received serial byte per word; every three bytes
// form one frame for the current encoder, and encoders are served round-robin.
// Output channel res carries one word per frame: channel, pass flag, angle, turn
// count, packed position and consecutive miss count of that encoder.
// Configuration: cfg_we/cfg_index/cfg_data write the wrap high (index 0) and wrap
// low (index 1) thresholds; write only while no frame is in flight.
// Throughput: one byte per cycle, sustained while the receiver takes results; the front end,
// a two-entry frame queue and the tracker each stall on their own.
// Result path: after its third byte is taken, a frame is written into a queue slot,
// then into the tracker's result register, from which its result is offered.
// Reset: byte position, channel pointer, queue, counters and angles clear; channel
// 0 starts at angle 512, thresholds return to 800 and 300.
// When the receiver stalls, the held result stays, the queue fills, and rx.ready
// drops only on a third byte with the queue full.
// depends on enc_mt_pkg, enc_mt_ifs, enc_mt_front, enc_mt_queue, enc_mt_back
module encoder_frame_multiturn_tracker_top #(
	parameter int CHANNELS = enc_mt_pkg::CHANNELS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	enc_mt_byte_if.sink                           rx,
	enc_mt_result_if.source                       res,
	input  logic                                  cfg_we,
	input  logic [enc_mt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [enc_mt_pkg::CFG_DATA_W-1:0]     cfg_data
);

	logic               push;
	logic               q_ready;
	logic               q_valid;
	logic               pop;
	enc_mt_pkg::frame_t wr_frame;
	enc_mt_pkg::frame_t rd_frame;
	enc_mt_pkg::cfg_wr_t cfg;

	assign cfg.we   = cfg_we;
	assign cfg.idx  = cfg_index;
	assign cfg.data = cfg_data;

	enc_mt_front #(.CHANNELS(CHANNELS)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx      (rx),
		.push    (push),
		.frame   (wr_frame),
		.q_ready (q_ready)
	);

	enc_mt_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_frame (wr_frame),
		.wr_ready (q_ready),
		.pop      (pop),
		.rd_frame (rd_frame),
		.rd_valid (q_valid)
	);

	enc_mt_back #(.CHANNELS(CHANNELS)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.q_valid (q_valid),
		.q_frame (rd_frame),
		.pop     (pop),
		.res     (res)
	);

endmodule

// ===== verif/tb_encoder_frame_multiturn_tracker_top.sv =====
// self-checking testbench of encoder_frame_multiturn_tracker_top: directed frame table,
// rejected-frame run, then random frames under several idle/stall phases
// depends on enc_mt_pkg, enc_mt_ifs and the rtl of the tracker
module tb_encoder_frame_multiturn_tracker_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 300;
	localparam int SAT_FRAMES     = 8;
	localparam int PHASE_FRAMES   = 120;

	typedef logic [enc_mt_pkg::ANGLE_W-1:0] angle_t;
	typedef logic [enc_mt_pkg::COUNT_W-1:0] count_t;

	typedef enum logic [2:0] {
		FLAW_NONE, FLAW_PARITY, FLAW_NO_STATUS, FLAW_FAULT, FLAW_NOISE
	} flaw_t;

	typedef enum logic {ROW_FRAME, ROW_CFG} row_kind_t;

	typedef struct packed {
		logic   channel;
		logic   frame_valid;
		angle_t angle;
		count_t turns;
		count_t position;
		count_t miss_count;
	} frame_result_t;

	typedef struct {
		bit            given;
		frame_result_t res;
	} typed_frame_t;

	typedef struct {
		row_kind_t            kind;
		logic [23:0]          bytes;
		angle_t               hi;
		angle_t               lo;
		bit                   given;
		frame_result_t        res;
	} stim_row_t;

	logic                                 clk = 1'b0;
	logic                                 arst_n = 1'b0;
	logic                                 cfg_we;
	logic [enc_mt_pkg::CFG_IDX_W-1:0]     cfg_index;
	logic [enc_mt_pkg::CFG_DATA_W-1:0]    cfg_data;

	enc_mt_byte_if   rx_if ();
	enc_mt_result_if res_if ();

	encoder_frame_multiturn_tracker_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx_if),
		.res       (res_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5ns clk = ~clk;

	// tracker state, mirrors the block
	logic [1:0] trk_pos;
	logic [7:0] trk_b0;
	logic [7:0] trk_b1;
	logic       trk_ch;
	angle_t     trk_angle [2];
	count_t     trk_turns [2];
	count_t     trk_miss [2];
	count_t     trk_position [2];
	angle_t     trk_hi;
	angle_t     trk_lo;

	frame_result_t pending_frames [$];
	typed_frame_t  typed_frames [$];
	stim_row_t     stim_rows [$];

	int err_cnt = 0;
	int idle_cycles = 0;
	int src_idle_pct = 0;
	int snk_stall_pct = 0;
	int hold_left = 0;

	function automatic frame_result_t mk_result(input logic ch, input logic fv,
			input angle_t a, input count_t t, input count_t p, input count_t m);
		frame_result_t r;
		r.channel = ch;
		r.frame_valid = fv;
		r.angle = a;
		r.turns = t;
		r.position = p;
		r.miss_count = m;
		return r;
	endfunction

	// three bytes of a frame carrying angle a, free bits random, with at most one flaw
	function automatic logic [23:0] frame_bytes(input angle_t a, input flaw_t flaw);
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic       par;
		b0 = 8'($urandom);
		b1 = 8'($urandom);
		b2 = 8'($urandom);
		b0[6:0] = a[9:3];
		b1[7:5] = a[2:0];
		b1[4] = (flaw != FLAW_NO_STATUS);
		b1[3] = (flaw == FLAW_FAULT);
		par = ^{b0[6:0], b1};
		b2[7] = (flaw == FLAW_PARITY) ? ~par : par;
		if (flaw == FLAW_NOISE) begin
			return 24'($urandom);
		end
		return {b0, b1, b2};
	endfunction

	function automatic stim_row_t mk_frame_row(input logic [23:0] bytes, input bit given,
			input frame_result_t res);
		stim_row_t row;
		row.kind = ROW_FRAME;
		row.bytes = bytes;
		row.hi = '0;
		row.lo = '0;
		row.given = given;
		row.res = res;
		return row;
	endfunction

	task automatic track_byte(input logic [7:0] b);
		logic [14:0]        data;
		logic               ok;
		angle_t             a;
		frame_result_t      r;
		typed_frame_t       row;
		case (trk_pos)
			2'd0: begin
				trk_b0 = b;
				trk_pos = 2'd1;
			end
			2'd1: begin
				trk_b1 = b;
				trk_pos = 2'd2;
			end
			default: begin
				trk_pos = 2'd0;
				data = {trk_b0[6:0], trk_b1};
				ok = (^data == b[7]) && trk_b1[4] && !trk_b1[3];
				a = data[14:5];
				if (ok) begin
					trk_miss[trk_ch] = '0;
					// forward wrap takes priority when both conditions hold
					if (trk_angle[trk_ch] > trk_hi && a < trk_lo)
						trk_turns[trk_ch] = trk_turns[trk_ch] + 1'b1;
					else if (trk_angle[trk_ch] < trk_lo && a > trk_hi)
						trk_turns[trk_ch] = trk_turns[trk_ch] - 1'b1;
					trk_angle[trk_ch] = a;
					trk_position[trk_ch] = {trk_turns[trk_ch][5:0], a};
				end else if (trk_miss[trk_ch] != 16'hffff) begin
					trk_miss[trk_ch] = trk_miss[trk_ch] + 1'b1;
				end
				r = mk_result(trk_ch, ok, trk_angle[trk_ch], trk_turns[trk_ch],
					trk_position[trk_ch], trk_miss[trk_ch]);
				if (typed_frames.size() != 0) begin
					row = typed_frames.pop_front();
					if (row.given)
						r = row.res;
				end
				pending_frames.push_back(r);
				trk_ch = ~trk_ch;
			end
		endcase
	endtask

	task automatic compare_field(input string name, input logic [15:0] exp_v,
			input logic [15:0] got_v);
		if (exp_v !== got_v) begin
			err_cnt++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
		end
	endtask

	task automatic check_result();
		frame_result_t exp_r;
		if (pending_frames.size() == 0) begin
			err_cnt++;
			$display("%0t: result word with none expected, got channel %0d angle %0d",
				$time, res_if.channel, res_if.angle);
		end else begin
			exp_r = pending_frames.pop_front();
			compare_field("channel", 16'(exp_r.channel), 16'(res_if.channel));
			compare_field("frame_valid", 16'(exp_r.frame_valid), 16'(res_if.frame_valid));
			compare_field("angle", 16'(exp_r.angle), 16'(res_if.angle));
			compare_field("turns", exp_r.turns, res_if.turns);
			compare_field("position", exp_r.position, res_if.position);
			compare_field("miss_count", exp_r.miss_count, res_if.miss_count);
		end
	endtask

	// monitor and watchdog, sampled at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			idle_cycles++;
			if (rx_if.valid && rx_if.ready) begin
				track_byte(rx_if.rx_byte);
				idle_cycles = 0;
			end
			if (res_if.valid && res_if.ready) begin
				check_result();
				idle_cycles = 0;
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb_encoder_frame_multiturn_tracker_top NOT OK");
				$finish;
			end
		end
	end

	// receiver side: random stalls plus an optional long hold-off
	initial begin
		res_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				res_if.ready <= 1'b0;
				hold_left--;
			end else begin
				res_if.ready <= ($urandom_range(99) >= snk_stall_pct);
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < src_idle_pct) begin
			rx_if.valid <= 1'b0;
			@(negedge clk);
		end
		rx_if.valid <= 1'b1;
		rx_if.rx_byte <= b;
		do begin
			@(posedge clk);
		end while (!rx_if.ready);
		@(negedge clk);
	endtask

	task automatic send_frame(input logic [23:0] bytes);
		send_byte(bytes[23:16]);
		send_byte(bytes[15:8]);
		send_byte(bytes[7:0]);
	endtask

	task automatic send_random_frame();
		angle_t             a;
		flaw_t              flaw;
		int                 pick;
		// bias angles toward the wrap zones so turns move often
		pick = $urandom_range(99);
		if (pick < 40)
			a = angle_t'($urandom_range(trk_lo, 0));
		else if (pick < 80)
			a = angle_t'($urandom_range(1023, trk_hi));
		else
			a = angle_t'($urandom_range(1023));
		pick = $urandom_range(99);
		if (pick < 78)
			flaw = FLAW_NONE;
		else if (pick < 84)
			flaw = FLAW_PARITY;
		else if (pick < 89)
			flaw = FLAW_NO_STATUS;
		else if (pick < 94)
			flaw = FLAW_FAULT;
		else
			flaw = FLAW_NOISE;
		send_frame(frame_bytes(a, flaw));
	endtask

	task automatic wait_drained();
		rx_if.valid <= 1'b0;
		while (pending_frames.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_thresholds(input angle_t hi, input angle_t lo);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_index <= enc_mt_pkg::CFG_WRAP_HIGH;
		cfg_data <= hi;
		@(negedge clk);
		cfg_index <= enc_mt_pkg::CFG_WRAP_LOW;
		cfg_data <= lo;
		@(negedge clk);
		cfg_we <= 1'b0;
		trk_hi = hi;
		trk_lo = lo;
	endtask

	initial begin
		stim_row_t     row;
		typed_frame_t  tf;
		frame_result_t none;
		int            sel;
		none = '0;
		rx_if.valid = 1'b0;
		rx_if.rx_byte = '0;
		cfg_we = 1'b0;
		cfg_index = enc_mt_pkg::CFG_WRAP_HIGH;
		cfg_data = '0;
		trk_pos = '0;
		trk_b0 = '0;
		trk_b1 = '0;
		trk_ch = 1'b0;
		trk_hi = enc_mt_pkg::WRAP_HIGH_RST;
		trk_lo = enc_mt_pkg::WRAP_LOW_RST;
		for (int c = 0; c < 2; c++) begin
			trk_angle[c] = (c == 0) ? enc_mt_pkg::ANGLE_CH0_RST : '0;
			trk_turns[c] = '0;
			trk_miss[c] = '0;
			trk_position[c] = '0;
		end

		// directed frames, channels alternate starting at 0
		stim_rows.push_back(mk_frame_row(frame_bytes(10'd0, FLAW_NONE), 1'b1,
			mk_result(1'b0, 1'b1, 10'd0, 16'd0, 16'd0, 16'd0)));
		stim_rows.push_back(mk_frame_row(24'h000000, 1'b1,
			mk_result(1'b1, 1'b0, 10'd0, 16'd0, 16'd0, 16'd1)));
		stim_rows.push_back(mk_frame_row(24'hffffff, 1'b1,
			mk_result(1'b0, 1'b0, 10'd0, 16'd0, 16'd0, 16'd1)));
		stim_rows.push_back(mk_frame_row(frame_bytes(10'd1023, FLAW_PARITY), 1'b1,
			mk_result(1'b1, 1'b0, 10'd0, 16'd0, 16'd0, 16'd2)));
		// backward wrap from zero turns
		stim_rows.push_back(mk_frame_row(frame_bytes(10'd1023, FLAW_NONE), 1'b1,
			mk_result(1'b0, 1'b1, 10'd1023, 16'hffff, 16'hffff, 16'd0)));
		stim_rows.push_back(mk_frame_row(frame_bytes(10'd900, FLAW_NONE), 1'b0, none));
		// forward wrap back to zero turns
		stim_rows.push_back(mk_frame_row(frame_bytes(10'd10, FLAW_NONE), 1'b1,
			mk_result(1'b0, 1'b1, 10'd10, 16'd0, 16'd10, 16'd0)));
		// crossed thresholds so both wrap conditions can hold at once
		row.kind = ROW_CFG;
		row.bytes = '0;
		row.hi = 10'd100;
		row.lo = 10'd950;
		row.given = 1'b0;
		row.res = none;
		stim_rows.push_back(row);
		stim_rows.push_back(mk_frame_row(frame_bytes(10'd500, FLAW_NONE), 1'b0, none));
		stim_rows.push_back(mk_frame_row(frame_bytes(10'd0, FLAW_NO_STATUS), 1'b1,
			mk_result(1'b0, 1'b0, 10'd10, 16'd0, 16'd10, 16'd1)));

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (stim_rows[i]) begin
			if (stim_rows[i].kind == ROW_CFG) begin
				write_thresholds(stim_rows[i].hi, stim_rows[i].lo);
			end else begin
				tf.given = stim_rows[i].given;
				tf.res = stim_rows[i].res;
				typed_frames.push_back(tf);
				send_frame(stim_rows[i].bytes);
			end
		end

		// run of rejected frames on channel 0
		write_thresholds(enc_mt_pkg::WRAP_HIGH_RST, enc_mt_pkg::WRAP_LOW_RST);
		for (int i = 0; i < SAT_FRAMES; i++) begin
			if (trk_ch == 1'b0) begin
				sel = $urandom_range(2);
				send_frame(frame_bytes(angle_t'($urandom), (sel == 0) ? FLAW_PARITY :
					(sel == 1) ? FLAW_NO_STATUS : FLAW_FAULT));
			end else begin
				send_random_frame();
			end
		end

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					write_thresholds(angle_t'($urandom_range(1023)),
						angle_t'($urandom_range(1023)));
					src_idle_pct = 0;
					snk_stall_pct = 0;
				end
				1: begin
					write_thresholds(10'd0, 10'd1023);
					src_idle_pct = 54;
					snk_stall_pct = 0;
				end
				2: begin
					write_thresholds(10'd1023, 10'd0);
					src_idle_pct = 0;
					snk_stall_pct = 54;
				end
				default: begin
					write_thresholds(angle_t'($urandom_range(1023)),
						angle_t'($urandom_range(1023)));
					src_idle_pct = 38;
					snk_stall_pct = 38;
				end
			endcase
			for (int i = 0; i < PHASE_FRAMES; i++) begin
				if (i == PHASE_FRAMES / 2) begin
					// phase 0: receiver holds off while bytes keep coming, so the queue fills; phase 2: drain first
					if (ph == 0)
						hold_left = HOLD_CYCLES;
					else if (ph == 2)
						wait_drained();
				end
				send_random_frame();
			end
		end

		wait_drained();
		repeat (8) @(negedge clk);
		if (err_cnt == 0 && pending_frames.size() == 0) begin
			$display("tb_encoder_frame_multiturn_tracker_top OK");
		end else begin
			$display("tb_encoder_frame_multiturn_tracker_top NOT OK");
		end
		$finish;
	end

endmodule
